/* src/vps_pkg.sv */
`default_nettype none
package vps_pkg;

    localparam int unsigned DEF_CHUNK_EDGE   = 32;
    localparam int unsigned DEF_PALETTE_SIZE = 256;
    localparam int unsigned DEF_KEY_BITS     = 16;

    localparam int unsigned MATCH_GROUP = 16;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_GROUP,
        ST_SELECT,
        ST_WRITE,
        ST_FREE,
        ST_DONE
    } vps_state_t;

    typedef struct packed {
        logic clr;
        logic accept;
        logic rd_cell;
        logic group;
        logic sel_id;
        logic wr_new;
        logic rel_old;
        logic load_out;
    } vps_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } vps_status_t;

    function automatic logic [4:0] wrap_coord(input logic [4:0] v, input int unsigned span);
        logic [5:0] r;
        r = {1'b0, v};
        for (int i = 0; i < 8; i++)
        begin
            if (r >= 6'(span))
            begin
                r = r - 6'(span);
            end
        end
        return r[4:0];
    endfunction

endpackage
`default_nettype wire

/* src/vps_ctrl.sv */
`default_nettype none
module vps_ctrl
    import vps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire vps_status_t stat,
    output vps_cmd_t         cmd
);

    vps_state_t state_reg;
    vps_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.rd_cell = 1'b1;
                state_next  = ST_GROUP;
            end
            ST_GROUP:
            begin
                cmd.group  = 1'b1;
                state_next = ST_SELECT;
            end
            ST_SELECT:
            begin
                cmd.sel_id = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                cmd.wr_new = 1'b1;
                state_next = ST_FREE;
            end
            ST_FREE:
            begin
                cmd.rel_old = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/vps_dp.sv */
`default_nettype none
module vps_dp
    import vps_pkg::*;
#(
    parameter int unsigned CHUNK_EDGE   = DEF_CHUNK_EDGE,
    parameter int unsigned PALETTE_SIZE = DEF_PALETTE_SIZE,
    parameter int unsigned KEY_BITS     = DEF_KEY_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire vps_cmd_t    cmd,
    output vps_status_t      stat,
    input  wire logic        cfg_wr,
    input  wire logic        cfg_hit,
    input  wire logic [31:0] cfg_wdata,
    output logic [31:0]      cfg_rdata,
    input  wire logic        op,
    input  wire logic [4:0]  pos_x,
    input  wire logic [4:0]  pos_y,
    input  wire logic [4:0]  pos_z,
    input  wire logic [15:0] block_key,
    input  wire logic        is_transparent,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       old_id,
    output logic [7:0]       new_id,
    output logic [15:0]      old_key,
    output logic             old_freed,
    output logic             status
);

    localparam int unsigned VOLUME  = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
    localparam int unsigned COLUMNS = CHUNK_EDGE * CHUNK_EDGE;
    localparam int unsigned CELL_AW = $clog2(VOLUME);
    localparam int unsigned COL_AW  = $clog2(COLUMNS);
    localparam int unsigned Z_W     = $clog2(CHUNK_EDGE);
    localparam int unsigned ID_W    = $clog2(PALETTE_SIZE);
    localparam int unsigned CNT_W   = $clog2(PALETTE_SIZE + 1);
    localparam int unsigned NGRP    = (PALETTE_SIZE + MATCH_GROUP - 1) / MATCH_GROUP;
    localparam int unsigned GI_W    = $clog2(MATCH_GROUP);
    localparam int unsigned RC0     = (VOLUME > 65535) ? 65535 : VOLUME;

    logic [CELL_AW-1:0] clr_cnt_reg;

    logic               op_reg;
    logic [4:0]         x_reg;
    logic [4:0]         y_reg;
    logic [4:0]         z_reg;
    logic [KEY_BITS-1:0] key_reg;
    logic               transp_reg;
    logic [15:0]        air_key_reg;

    logic [KEY_BITS-1:0] cam_reg [PALETTE_SIZE];
    logic [PALETTE_SIZE-1:0] bound_reg;
    logic [PALETTE_SIZE-1:0] rc_valid_reg;
    logic [NGRP*MATCH_GROUP-1:0] match_reg;
    logic [NGRP-1:0]    grp_hit_reg;
    logic [GI_W-1:0]    grp_idx_reg [NGRP];

    logic [ID_W-1:0]    cell_mem [VOLUME];
    logic [CHUNK_EDGE-1:0] trans_mem [COLUMNS];
    logic [KEY_BITS-1:0] key_mem [PALETTE_SIZE];
    logic [15:0]        rc_mem [PALETTE_SIZE];
    logic [ID_W-1:0]    q_mem [PALETTE_SIZE];

    logic [ID_W-1:0]    cell_q;
    logic [CHUNK_EDGE-1:0] trans_q;
    logic [KEY_BITS-1:0] key_q;
    logic [15:0]        rc_q;
    logic               rcv_q;
    logic [ID_W-1:0]    rc_addr_q;
    logic [ID_W-1:0]    q_q;

    logic [ID_W-1:0]    head_reg;
    logic [ID_W-1:0]    tail_reg;
    logic [CNT_W-1:0]   fcount_reg;
    logic [CNT_W-1:0]   next_id_reg;

    logic [ID_W-1:0]    old_id_reg;
    logic [ID_W-1:0]    new_id_reg;
    logic [KEY_BITS-1:0] old_key_reg;
    logic [15:0]        rc_old_reg;
    logic               bind_reg;
    logic               pop_reg;
    logic               bump_reg;
    logic               full_reg;
    logic               freed_reg;
    logic               out_valid_reg;

    logic [COL_AW-1:0]  col_addr;
    logic [CELL_AW-1:0] cell_addr;
    logic [31:0]        key_ext;
    logic [31:0]        air_ext;
    logic [31:0]        okey_ext;
    logic               found_c;
    logic [ID_W-1:0]    found_id_c;
    logic [ID_W-1:0]    new_id_c;
    logic               bind_c;
    logic               pop_c;
    logic               bump_c;
    logic               full_c;
    logic [ID_W-1:0]    rc_raddr;
    logic [15:0]        rc_eff;
    logic               counting;
    logic [CHUNK_EDGE-1:0] trans_new;

    assign key_ext   = 32'(block_key);
    assign air_ext   = 32'(cfg_wdata[15:0]);
    assign col_addr  = COL_AW'(32'(x_reg) * CHUNK_EDGE + 32'(y_reg));
    assign cell_addr = CELL_AW'(32'(col_addr) * CHUNK_EDGE + 32'(z_reg));
    assign cfg_rdata = cfg_hit ? {16'd0, air_key_reg} : 32'd0;
    assign counting  = !op_reg && (new_id_reg != old_id_reg);
    assign rc_eff    = rcv_q ? rc_q : ((rc_addr_q == '0) ? 16'(RC0) : 16'd0);
    assign rc_raddr  = cmd.sel_id ? new_id_c : cell_q;

    assign stat.clear_last = (clr_cnt_reg == CELL_AW'(VOLUME - 1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        trans_new = trans_q;
        trans_new[z_reg[Z_W-1:0]] = transp_reg;
    end

    always_comb
    begin
        found_c    = 1'b0;
        found_id_c = '0;
        for (int g = NGRP - 1; g >= 0; g--)
        begin
            if (grp_hit_reg[g])
            begin
                found_c    = 1'b1;
                found_id_c = ID_W'(g * MATCH_GROUP + int'(grp_idx_reg[g]));
            end
        end
        bind_c   = 1'b0;
        pop_c    = 1'b0;
        bump_c   = 1'b0;
        full_c   = 1'b0;
        new_id_c = cell_q;
        priority if (found_c)
        begin
            new_id_c = found_id_c;
        end
        else if (!op_reg && (fcount_reg != '0))
        begin
            new_id_c = q_q;
            bind_c   = 1'b1;
            pop_c    = 1'b1;
        end
        else if (next_id_reg < CNT_W'(PALETTE_SIZE))
        begin
            new_id_c = next_id_reg[ID_W-1:0];
            bind_c   = 1'b1;
            bump_c   = 1'b1;
        end
        else
        begin
            full_c = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= op;
            x_reg      <= wrap_coord(pos_x, CHUNK_EDGE);
            y_reg      <= wrap_coord(pos_y, CHUNK_EDGE);
            z_reg      <= wrap_coord(pos_z, CHUNK_EDGE);
            key_reg    <= key_ext[KEY_BITS-1:0];
            transp_reg <= is_transparent;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            air_key_reg <= '0;
        end
        else if (cfg_wr && cfg_hit)
        begin
            air_key_reg <= cfg_wdata[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PALETTE_SIZE; i++)
            begin
                cam_reg[i] <= '0;
            end
        end
        else if (cfg_wr && cfg_hit)
        begin
            cam_reg[0] <= air_ext[KEY_BITS-1:0];
        end
        else if (cmd.wr_new && !full_reg && bind_reg)
        begin
            cam_reg[new_id_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg    <= PALETTE_SIZE'(1);
            rc_valid_reg <= '0;
        end
        else
        begin
            if (cmd.wr_new && !full_reg)
            begin
                if (bind_reg)
                begin
                    bound_reg[new_id_reg] <= 1'b1;
                end
                if (counting)
                begin
                    rc_valid_reg[new_id_reg] <= 1'b1;
                end
            end
            if (cmd.rel_old && !full_reg && counting && (rc_old_reg != 16'd0))
            begin
                rc_valid_reg[old_id_reg] <= 1'b1;
                if (rc_old_reg == 16'd1)
                begin
                    bound_reg[old_id_reg] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_cell)
        begin
            for (int i = 0; i < NGRP * MATCH_GROUP; i++)
            begin
                if (i < PALETTE_SIZE)
                begin
                    match_reg[i] <= bound_reg[i] && (cam_reg[i] == key_reg);
                end
                else
                begin
                    match_reg[i] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.group)
        begin
            for (int g = 0; g < NGRP; g++)
            begin
                grp_hit_reg[g] <= |match_reg[g*MATCH_GROUP +: MATCH_GROUP];
                grp_idx_reg[g] <= '0;
                for (int j = MATCH_GROUP - 1; j >= 0; j--)
                begin
                    if (match_reg[g*MATCH_GROUP + j])
                    begin
                        grp_idx_reg[g] <= GI_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            cell_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.wr_new && !full_reg)
        begin
            cell_mem[cell_addr] <= new_id_reg;
        end
        if (cmd.rd_cell)
        begin
            cell_q <= cell_mem[cell_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr && (32'(clr_cnt_reg) < COLUMNS))
        begin
            trans_mem[clr_cnt_reg[COL_AW-1:0]] <= '1;
        end
        else if (cmd.wr_new && !full_reg)
        begin
            trans_mem[col_addr] <= trans_new;
        end
        if (cmd.rd_cell)
        begin
            trans_q <= trans_mem[col_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_new && !full_reg && bind_reg)
        begin
            key_mem[new_id_reg] <= key_reg;
        end
        key_q <= key_mem[cell_q];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_new && !full_reg && counting)
        begin
            rc_mem[new_id_reg] <= (rc_eff == 16'hFFFF) ? rc_eff : rc_eff + 16'd1;
        end
        else if (cmd.rel_old && !full_reg && counting && (rc_old_reg != 16'd0))
        begin
            rc_mem[old_id_reg] <= rc_old_reg - 16'd1;
        end
        rc_q      <= rc_mem[rc_raddr];
        rcv_q     <= rc_valid_reg[rc_raddr];
        rc_addr_q <= rc_raddr;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rel_old && !full_reg && counting && (rc_old_reg == 16'd1)
            && (fcount_reg < CNT_W'(PALETTE_SIZE)))
        begin
            q_mem[tail_reg] <= old_id_reg;
        end
        q_q <= q_mem[head_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fcount_reg  <= '0;
            next_id_reg <= CNT_W'(1);
        end
        else if (cmd.wr_new && !full_reg)
        begin
            if (pop_reg)
            begin
                head_reg   <= (head_reg == ID_W'(PALETTE_SIZE - 1)) ? '0 : head_reg + 1'b1;
                fcount_reg <= fcount_reg - 1'b1;
            end
            if (bump_reg)
            begin
                next_id_reg <= next_id_reg + 1'b1;
            end
        end
        else if (cmd.rel_old && !full_reg && counting && (rc_old_reg == 16'd1)
                 && (fcount_reg < CNT_W'(PALETTE_SIZE)))
        begin
            tail_reg   <= (tail_reg == ID_W'(PALETTE_SIZE - 1)) ? '0 : tail_reg + 1'b1;
            fcount_reg <= fcount_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sel_id)
        begin
            old_id_reg  <= cell_q;
            old_key_reg <= (cell_q == '0) ? cam_reg[0] : key_q;
            rc_old_reg  <= rc_eff;
            new_id_reg  <= new_id_c;
            bind_reg    <= bind_c;
            pop_reg     <= pop_c;
            bump_reg    <= bump_c;
            full_reg    <= full_c;
            freed_reg   <= 1'b0;
        end
        else if (cmd.rel_old && !full_reg && counting && (rc_old_reg == 16'd1))
        begin
            freed_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            okey_ext  <= 32'(old_key_reg);
            old_id    <= 8'(old_id_reg);
            new_id    <= 8'(new_id_reg);
            old_freed <= freed_reg;
            status    <= full_reg;
        end
    end

    assign old_key   = okey_ext[15:0];
    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

/* src/voxel_palette_store.sv */
// channel   direction  handshake            payload
// apb       in/out     psel/penable/pready  paddr, pwdata, prdata (air_key)
// in        in         in_valid/in_ready    op, pos_x/y/z, block_key, is_transparent
// out       out        out_valid/out_ready  old_id, new_id, old_key, old_freed, status
//
// A write beat passes through these steps in order: accept, cell read and match, group
// encode, id select, write, count release, result load; the staged key search and the
// read-modify-write of the memories call for them.
// After reset a clearing pass over all CHUNK_EDGE^3 cells fills cells and columns; no beat
// is taken until it ends. A stalled result holds the block in its last step.
`default_nettype none
module voxel_palette_store
    import vps_pkg::*;
#(
    parameter int unsigned CHUNK_EDGE   = DEF_CHUNK_EDGE,
    parameter int unsigned PALETTE_SIZE = DEF_PALETTE_SIZE,
    parameter int unsigned KEY_BITS     = DEF_KEY_BITS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        op,
    input  wire logic [4:0]  pos_x,
    input  wire logic [4:0]  pos_y,
    input  wire logic [4:0]  pos_z,
    input  wire logic [15:0] block_key,
    input  wire logic        is_transparent,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       old_id,
    output logic [7:0]       new_id,
    output logic [15:0]      old_key,
    output logic             old_freed,
    output logic             status
);

    vps_cmd_t    cmd;
    vps_status_t stat;

    assign pready = 1'b1;

    vps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vps_dp #(
        .CHUNK_EDGE   (CHUNK_EDGE),
        .PALETTE_SIZE (PALETTE_SIZE),
        .KEY_BITS     (KEY_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_wr         (psel && penable && pwrite),
        .cfg_hit        (!paddr[2]),
        .cfg_wdata      (pwdata),
        .cfg_rdata      (prdata),
        .op             (op),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .block_key      (block_key),
        .is_transparent (is_transparent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .old_id         (old_id),
        .new_id         (new_id),
        .old_key        (old_key),
        .old_freed      (old_freed),
        .status         (status)
    );

endmodule
`default_nettype wire
